@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ sv/mwd_pkg.sv @@
// ---------------------------------------------------------------------------
// mwd_pkg
// Shared widths, word types and job flags of the median window despiker.
// ---------------------------------------------------------------------------
package mwd_pkg;

  // Default configuration of the filter.
  localparam int unsigned WINDOW_DEFAULT     = 5;
  localparam int unsigned COUNT_BITS_DEFAULT = 16;

  // Fixed field widths.
  localparam int unsigned SV_W      = 22;
  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned COUNT_W   = 16;

  typedef logic [SV_W-1:0]      speed_t;
  typedef logic [PAYLOAD_W-1:0] record_t;

  // Input word: one sample of a cast.
  typedef struct packed {
    speed_t  sample_sv;
    record_t payload;
    logic    is_last;
  } sample_t;

  // Output word: one decided sample.
  typedef struct packed {
    speed_t             out_sv;
    record_t            out_payload;
    logic               keep;
    logic               last_of_cast;
    logic [COUNT_W-1:0] removed_count;
  } result_t;

  // Control flags of one decision job.
  typedef struct packed {
    logic test;  // compare against the median
    logic last;  // the job closes the cast
  } job_flags_t;

endpackage

@@ sv/mwd_window.sv @@
// ---------------------------------------------------------------------------
// mwd_window
// Sample window shift register, cast sample counter and registered median.
// On each accepted word it also works out which window slots become decided.
// ---------------------------------------------------------------------------
module mwd_window #(
  parameter int unsigned WINDOW = mwd_pkg::WINDOW_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  mwd_pkg::sample_t             sample,
  output mwd_pkg::speed_t              win_speed  [WINDOW],
  output mwd_pkg::record_t             win_record [WINDOW],
  output mwd_pkg::speed_t              median,
  output logic                         job_req,
  output logic [$clog2(WINDOW)-1:0]    job_from,
  output logic [$clog2(WINDOW)-1:0]    job_to,
  output mwd_pkg::job_flags_t          job_flags
);

  localparam int unsigned IDX_W = $clog2(WINDOW);
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned HALF  = WINDOW / 2;

  mwd_pkg::speed_t  speed_next  [WINDOW];
  mwd_pkg::record_t record_next [WINDOW];
  mwd_pkg::speed_t  median_next;
  logic [CNT_W-1:0] seen;
  logic [CNT_W-1:0] seen_inc;
  logic [CNT_W-1:0] lt_cnt [WINDOW];
  logic [CNT_W-1:0] le_cnt [WINDOW];

  // Window contents after the incoming sample is shifted in at the top.
  always_comb begin
    for (int i = 0; i < WINDOW - 1; i++) begin
      speed_next[i]  = win_speed[i+1];
      record_next[i] = win_record[i+1];
    end
    speed_next[WINDOW-1]  = sample.sample_sv;
    record_next[WINDOW-1] = sample.payload;
  end

  // Median by rank: a value is the median when at most HALF entries lie below
  // it and more than HALF lie at or below it.
  always_comb begin
    median_next = speed_next[0];
    for (int i = 0; i < WINDOW; i++) begin
      lt_cnt[i] = '0;
      le_cnt[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        lt_cnt[i] = lt_cnt[i] + CNT_W'(speed_next[j] <  speed_next[i]);
        le_cnt[i] = le_cnt[i] + CNT_W'(speed_next[j] <= speed_next[i]);
      end
      if ((lt_cnt[i] <= CNT_W'(HALF)) && (le_cnt[i] > CNT_W'(HALF))) begin
        median_next = speed_next[i];
      end
    end
  end

  // Sample count of the cast including the incoming one, saturating.
  assign seen_inc = (seen == CNT_W'(WINDOW)) ? seen : seen + 1'b1;

  // Range of window slots decided by the incoming sample.
  always_comb begin
    job_flags.last = sample.is_last;
    if (seen_inc < CNT_W'(WINDOW)) begin
      // Short cast so far: release everything unchecked at its end.
      job_req        = sample.is_last;
      job_from       = IDX_W'(CNT_W'(WINDOW) - seen_inc);
      job_to         = IDX_W'(WINDOW - 1);
      job_flags.test = 1'b0;
    end else begin
      job_req        = 1'b1;
      job_from       = (seen == CNT_W'(WINDOW - 1)) ? '0 : IDX_W'(HALF);
      job_to         = sample.is_last ? IDX_W'(WINDOW - 1) : IDX_W'(HALF);
      job_flags.test = 1'b1;
    end
  end

  // Cast sample counter; cleared by the closing sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (accept) begin
      seen <= sample.is_last ? '0 : seen_inc;
    end
  end

  // Window and median storage. Stale slots are never read once a new cast
  // starts, so they need no clearing.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < WINDOW; i++) begin
        win_speed[i]  <= speed_next[i];
        win_record[i] <= record_next[i];
      end
      median <= median_next;
    end
  end

endmodule

@@ sv/mwd_decide.sv @@
// ---------------------------------------------------------------------------
// mwd_decide
// Walks the decided window slots one per cycle while the output register is
// free, tests each against the median and tolerance, keeps the spike tally and drives that register.
// ---------------------------------------------------------------------------
module mwd_decide #(
  parameter int unsigned WINDOW     = mwd_pkg::WINDOW_DEFAULT,
  parameter int unsigned COUNT_BITS = mwd_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mwd_pkg::speed_t              tolerance,
  input  logic                         accept,
  input  logic                         job_req,
  input  logic [$clog2(WINDOW)-1:0]    job_from,
  input  logic [$clog2(WINDOW)-1:0]    job_to,
  input  mwd_pkg::job_flags_t          job_flags,
  input  mwd_pkg::speed_t              win_speed  [WINDOW],
  input  mwd_pkg::record_t             win_record [WINDOW],
  input  mwd_pkg::speed_t              median,
  output logic                         job_free,
  output logic                         result_valid,
  input  logic                         result_ready,
  output mwd_pkg::result_t             result
);

  localparam int unsigned IDX_W = $clog2(WINDOW);
  localparam int unsigned SHOW  = (COUNT_BITS < mwd_pkg::COUNT_W) ? COUNT_BITS
                                                                 : mwd_pkg::COUNT_W;

  logic                      job_valid;
  logic [IDX_W-1:0]          job_pos;
  logic [IDX_W-1:0]          job_end;
  mwd_pkg::job_flags_t       flags;
  logic [COUNT_BITS-1:0]     tally;
  logic [COUNT_BITS-1:0]     tally_next;
  logic                      adv;
  logic                      job_done;
  logic                      is_final;
  logic                      spike;
  mwd_pkg::speed_t           cur_sv;
  mwd_pkg::speed_t           diff;

  // One slot moves to the output register whenever that register is free.
  assign adv      = job_valid && (!result_valid || result_ready);
  assign job_done = adv && (job_pos == job_end);
  assign job_free = !job_valid || job_done;
  assign is_final = flags.last && (job_pos == job_end);

  // Spike test of the current slot.
  assign cur_sv = win_speed[job_pos];
  assign diff   = (cur_sv > median) ? cur_sv - median : median - cur_sv;
  assign spike  = flags.test && (tolerance != '0) && (diff > tolerance);

  // Saturating spike count including the current slot.
  assign tally_next = (spike && (tally != '1)) ? tally + 1'b1 : tally;

  // Job registers: slot range still to be emitted.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (accept) begin
      job_valid <= job_req;
    end else if (job_done) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_pos <= job_from;
      job_end <= job_to;
      flags   <= job_flags;
    end else if (adv) begin
      job_pos <= job_pos + 1'b1;
    end
  end

  // Spike tally of the current cast.
  always_ff @(posedge clk) begin
    if (rst) begin
      tally <= '0;
    end else if (adv) begin
      tally <= is_final ? '0 : tally_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.out_sv        <= cur_sv;
      result.out_payload   <= win_record[job_pos];
      result.keep          <= !spike;
      result.last_of_cast  <= is_final;
      result.removed_count <= is_final ? mwd_pkg::COUNT_W'(tally_next[SHOW-1:0]) : '0;
    end
  end

endmodule

@@ sv/median_window_despike.sv @@
// ---------------------------------------------------------------------------
// median_window_despike
// Flags spikes in a cast of sound-speed samples against the median of a
// window of WINDOW samples that is centered on each sample and clamped at the
// cast ends. Every sample comes out once, in order, with a keep flag; the word
// closing the cast carries the saturating spike count. Casts shorter than
// WINDOW pass unchanged, and a tolerance of zero keeps everything. While
// result_ready is high, the block emits one result word per cycle from its
// output register and takes one sample per cycle as long as each sample
// decides at most one earlier sample. A sample that decides k samples
// (WINDOW/2+1 when a cast's window first fills, up to WINDOW at the end of a
// cast, the whole cast for a short cast) holds sample_ready low until the last
// of them moves to the output register, as the single compare path reads one
// window slot per cycle while that register is free. The first result word
// that a sample decides passes the job registers and then the output register.
// sample_ready is low during reset. Write the tolerance only while idle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module median_window_despike #(
  parameter int unsigned WINDOW     = mwd_pkg::WINDOW_DEFAULT,
  parameter int unsigned COUNT_BITS = mwd_pkg::COUNT_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  mwd_pkg::speed_t    cfg_wdata,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  mwd_pkg::sample_t   sample,
  output logic               result_valid,
  input  logic               result_ready,
  output mwd_pkg::result_t   result
);

  localparam int unsigned IDX_W = $clog2(WINDOW);

  mwd_pkg::speed_t      tolerance;
  logic                 accept;
  logic                 job_free;
  logic                 job_req;
  logic [IDX_W-1:0]     job_from;
  logic [IDX_W-1:0]     job_to;
  mwd_pkg::job_flags_t  job_flags;
  mwd_pkg::speed_t      win_speed  [WINDOW];
  mwd_pkg::record_t     win_record [WINDOW];
  mwd_pkg::speed_t      median;

  // Tolerance register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= '0;
    end else if (cfg_we) begin
      tolerance <= cfg_wdata;
    end
  end

  // A word is taken once the pending decisions are done or finishing, and
  // never while the block is in reset.
  assign sample_ready = job_free && !rst;
  assign accept       = sample_valid && sample_ready;

  mwd_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .sample     (sample),
    .win_speed  (win_speed),
    .win_record (win_record),
    .median     (median),
    .job_req    (job_req),
    .job_from   (job_from),
    .job_to     (job_to),
    .job_flags  (job_flags)
  );

  mwd_decide #(
    .WINDOW     (WINDOW),
    .COUNT_BITS (COUNT_BITS)
  ) u_decide (
    .clk          (clk),
    .rst          (rst),
    .tolerance    (tolerance),
    .accept       (accept),
    .job_req      (job_req),
    .job_from     (job_from),
    .job_to       (job_to),
    .job_flags    (job_flags),
    .win_speed    (win_speed),
    .win_record   (win_record),
    .median       (median),
    .job_free     (job_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // The spike count is reported only on the word that closes a cast.
  `ASSERT_CLK(a_count_on_last, result_valid && !result.last_of_cast |-> result.removed_count == '0, "removed_count set on a word that does not close the cast")

  // Nothing is dropped while the filter is disabled.
  `ASSERT_NEVER(a_drop_needs_tol, result_valid && !result.keep && (tolerance == '0), "sample dropped with zero tolerance")

endmodule
